/* rtl/lpse_pkg.sv */
package lpse_pkg;

    localparam int TICK_W = 15;
    localparam int IDX_W  = 6;
    localparam int REG_W  = 2;
    localparam int STEP_W = 4;

    localparam logic [REG_W-1:0] REG_SHORT_TICKS = 2'd0;
    localparam logic [REG_W-1:0] REG_LONG_TICKS  = 2'd1;
    localparam logic [REG_W-1:0] REG_RESET_TICKS = 2'd2;

    localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 15'd36;
    localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 15'd72;
    localparam logic [TICK_W-1:0] RESET_TICKS_RST = 15'd2000;
    localparam logic [TICK_W-1:0] TICK_MAX        = 15'h7FFF;

    localparam logic [STEP_W-1:0] FINAL_BIT_STEP = 4'd7;
    localparam logic [STEP_W-1:0] MARKER_STEP    = 4'd8;

    typedef struct packed {
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] reset_ticks;
    } lpse_cfg_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             last_byte;
        logic [IDX_W-1:0] base_index;
        logic [IDX_W-1:0] marker_index;
    } lpse_entry_t;

endpackage

/* rtl/lpse_if.sv */
interface lpse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lpse_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  word_index;
    logic [14:0] high_ticks;
    logic        high_level;
    logic [14:0] low_ticks;
    logic        low_level;
    logic        end_marker;
    logic        last_result;

    modport source (
        output valid, output word_index, output high_ticks, output high_level,
        output low_ticks, output low_level, output end_marker, output last_result,
        input ready
    );
    modport sink (
        input valid, input word_index, input high_ticks, input high_level,
        input low_ticks, input low_level, input end_marker, input last_result,
        output ready
    );
endinterface

/* rtl/lpse_front.sv */
module lpse_front
    import lpse_pkg::*;
#(
    parameter int HALF_WORDS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    lpse_in_if.sink       bytes,
    input  logic          queue_full,
    output logic          push,
    output lpse_entry_t   push_entry
);

    localparam int SLOTS_PER_HALF = HALF_WORDS / 8;
    localparam int SLOT_COUNT     = 2 * SLOTS_PER_HALF;
    localparam int SLOT_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_W-1:0] SPH_S     = SLOT_W'(SLOTS_PER_HALF);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [IDX_W-1:0]  HALF_OFS  = IDX_W'(HALF_WORDS % 64);

    logic [SLOT_W-1:0] byte_slot_reg;
    logic [SLOT_W-1:0] byte_slot_next;
    logic [SLOT_W-1:0] next_slot;

    function automatic logic [IDX_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
        logic              upper;
        logic [SLOT_W-1:0] inner;
        logic [7:0]        inner8;
        upper  = (slot >= SPH_S);
        inner  = upper ? (slot - SPH_S) : slot;
        inner8 = 8'(inner);
        return {inner8[2:0], 3'b000} + (upper ? HALF_OFS : '0);
    endfunction

    assign bytes.ready = !queue_full;
    assign push        = bytes.valid && !queue_full;
    assign next_slot   = (byte_slot_reg == SLOT_LAST) ? '0 : byte_slot_reg + 1'b1;

    always_comb
    begin
        push_entry.data_byte    = bytes.data_byte;
        push_entry.last_byte    = bytes.last_byte;
        push_entry.base_index   = slot_base(byte_slot_reg);
        push_entry.marker_index = slot_base(next_slot);
    end

    always_comb
    begin
        byte_slot_next = byte_slot_reg;
        if (push)
        begin
            byte_slot_next = bytes.last_byte ? '0 : next_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_slot_reg <= '0;
        end
        else
        begin
            byte_slot_reg <= byte_slot_next;
        end
    end

endmodule

/* rtl/lpse_queue.sv */
module lpse_queue
    import lpse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lpse_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output lpse_entry_t pop_entry,
    output logic        not_empty
);

    lpse_entry_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/lpse_back.sv */
module lpse_back
    import lpse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lpse_cfg_t   cfg,
    input  logic        entry_valid,
    input  lpse_entry_t entry,
    output logic        pop,
    lpse_out_if.source  symbols
);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [7:0]        data_reg;
    logic [7:0]        data_next;
    logic              last_reg;
    logic [IDX_W-1:0]  base_reg;
    logic [IDX_W-1:0]  marker_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [IDX_W-1:0]  out_index_reg;
    logic [TICK_W-1:0] out_high_reg;
    logic              out_hlevel_reg;
    logic [TICK_W-1:0] out_low_reg;
    logic              out_marker_reg;
    logic              out_last_reg;

    logic              out_adv;
    logic              advance;
    logic              is_marker;
    logic              is_final_bit;
    logic              done;
    logic              load;
    logic [TICK_W-1:0] tick_sel;
    logic [TICK_W:0]   tick_sum;
    logic [TICK_W-1:0] low_val;

    assign out_adv      = !out_valid_reg || symbols.ready;
    assign advance      = busy_reg && out_adv;
    assign is_marker    = (step_reg == MARKER_STEP);
    assign is_final_bit = (step_reg == FINAL_BIT_STEP);
    assign done         = is_marker || (is_final_bit && !last_reg);
    assign load         = entry_valid && (!busy_reg || (advance && done));
    assign pop          = load;

    assign tick_sel = data_reg[7] ? cfg.long_ticks : cfg.short_ticks;
    assign tick_sum = {1'b0, tick_sel} + {1'b0, cfg.reset_ticks};
    assign low_val  = (is_final_bit && last_reg)
                      ? (tick_sum[TICK_W] ? TICK_MAX : tick_sum[TICK_W-1:0])
                      : tick_sel;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        data_next = data_reg;
        if (advance)
        begin
            step_next = step_reg + 1'b1;
            data_next = {data_reg[6:0], 1'b0};
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            step_next = '0;
            data_next = entry.data_byte;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (symbols.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (load)
        begin
            last_reg   <= entry.last_byte;
            base_reg   <= entry.base_index;
            marker_reg <= entry.marker_index;
        end
        if (advance)
        begin
            out_index_reg  <= is_marker ? marker_reg : base_reg + IDX_W'(step_reg);
            out_high_reg   <= is_marker ? '0 : tick_sel;
            out_hlevel_reg <= !is_marker;
            out_low_reg    <= is_marker ? '0 : low_val;
            out_marker_reg <= is_marker;
            out_last_reg   <= done;
        end
    end

    assign symbols.valid       = out_valid_reg;
    assign symbols.word_index  = out_index_reg;
    assign symbols.high_ticks  = out_high_reg;
    assign symbols.high_level  = out_hlevel_reg;
    assign symbols.low_ticks   = out_low_reg;
    assign symbols.low_level   = 1'b0;
    assign symbols.end_marker  = out_marker_reg;
    assign symbols.last_result = out_last_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg <= MARKER_STEP))
        else $error("sequencer step out of range");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && is_marker) |-> last_reg)
        else $error("end marker step on a byte that does not close the frame");

    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg != '0) |-> $past(busy_reg))
        else $error("sequencer started mid byte");

endmodule

/* rtl/led_pulse_symbol_encoder.sv */
// Path: an accepted byte goes through the queue and the back-end sequencer into the output
// register. Throughput: 8 symbols per byte, 9 for a frame's last byte (end marker), one
// symbol per cycle while not stalled; a two-entry queue lets the front take bytes meanwhile.
// Reset: async active low; clears slot counter, queue and sequencer, and loads the
// tick registers with 36, 72 and 2000.
module led_pulse_symbol_encoder
    import lpse_pkg::*;
#(
    parameter int HALF_WORDS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [REG_W-1:0]  cfg_index,
    input  logic [TICK_W-1:0] cfg_data,
    lpse_in_if.sink           bytes,
    lpse_out_if.source        symbols
);

    lpse_cfg_t   cfg_reg;
    lpse_cfg_t   cfg_next;
    logic        queue_full;
    logic        push;
    lpse_entry_t push_entry;
    logic        pop;
    lpse_entry_t pop_entry;
    logic        not_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHORT_TICKS: cfg_next.short_ticks = cfg_data;
                REG_LONG_TICKS:  cfg_next.long_ticks  = cfg_data;
                REG_RESET_TICKS: cfg_next.reset_ticks = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_ticks <= SHORT_TICKS_RST;
            cfg_reg.long_ticks  <= LONG_TICKS_RST;
            cfg_reg.reset_ticks <= RESET_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lpse_front #(
        .HALF_WORDS (HALF_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    lpse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .not_empty  (not_empty)
    );

    lpse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .entry_valid (not_empty),
        .entry       (pop_entry),
        .pop         (pop),
        .symbols     (symbols)
    );

endmodule

/* tb/sv/symbol_stream_check.sv */
`timescale 1ns / 100ps

module symbol_stream_check
    import lpse_pkg::*;
#(
    parameter int HALF_WORDS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [REG_W-1:0]  cfg_index,
    input  logic [TICK_W-1:0] cfg_data,
    lpse_in_if                bytes,
    lpse_out_if               symbols,
    output int                mismatch_count,
    output int                symbols_due
);

    localparam int SLOTS_PER_HALF = HALF_WORDS / 8;
    localparam int SLOT_COUNT     = 2 * SLOTS_PER_HALF;

    typedef struct packed {
        logic [IDX_W-1:0]  word_index;
        logic [TICK_W-1:0] high_ticks;
        logic              high_level;
        logic [TICK_W-1:0] low_ticks;
        logic              low_level;
        logic              end_marker;
        logic              last_result;
    } symbol_t;

    lpse_cfg_t timing;
    int        byte_slot;
    symbol_t   expected_symbols[$];

    function automatic logic [IDX_W-1:0] ring_word(input int slot, input int bit_pos);
        int half;
        half = slot / SLOTS_PER_HALF;
        return IDX_W'(half * HALF_WORDS + (slot % SLOTS_PER_HALF) * 8 + bit_pos);
    endfunction

    function automatic void encode_byte(input logic [7:0] value, input logic is_last);
        symbol_t           sym;
        logic [TICK_W-1:0] phase;
        int                stretched;
        int                next_slot;
        next_slot = (byte_slot + 1) % SLOT_COUNT;
        for (int b = 0; b < 8; b++)
        begin
            phase          = value[7-b] ? timing.long_ticks : timing.short_ticks;
            sym            = '0;
            sym.word_index = ring_word(byte_slot, b);
            sym.high_ticks = phase;
            sym.high_level = 1'b1;
            sym.low_ticks  = phase;
            if (b == 7 && is_last)
            begin
                // stretch the final low phase by the frame gap, clamp at the top
                stretched     = int'(phase) + int'(timing.reset_ticks);
                sym.low_ticks = (stretched > int'(TICK_MAX)) ? TICK_MAX : TICK_W'(stretched);
            end
            sym.last_result = (b == 7) && !is_last;
            expected_symbols.push_back(sym);
        end
        if (is_last)
        begin
            sym             = '0;
            sym.word_index  = ring_word(next_slot, 0);
            sym.end_marker  = 1'b1;
            sym.last_result = 1'b1;
            expected_symbols.push_back(sym);
            byte_slot = 0;
        end
        else
        begin
            byte_slot = next_slot;
        end
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        symbol_t want;
        if (!rst_n)
        begin
            timing.short_ticks = SHORT_TICKS_RST;
            timing.long_ticks  = LONG_TICKS_RST;
            timing.reset_ticks = RESET_TICKS_RST;
            byte_slot          = 0;
            mismatch_count     = 0;
            expected_symbols.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SHORT_TICKS: timing.short_ticks = cfg_data;
                    REG_LONG_TICKS:  timing.long_ticks  = cfg_data;
                    REG_RESET_TICKS: timing.reset_ticks = cfg_data;
                    default: ;
                endcase
            end
            if (symbols.valid && symbols.ready)
            begin
                if (expected_symbols.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected symbol, expected none, actual index %0d",
                             $time, symbols.word_index);
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    check_field("word_index", want.word_index, symbols.word_index);
                    check_field("high_ticks", want.high_ticks, symbols.high_ticks);
                    check_field("high_level", want.high_level, symbols.high_level);
                    check_field("low_ticks", want.low_ticks, symbols.low_ticks);
                    check_field("low_level", want.low_level, symbols.low_level);
                    check_field("end_marker", want.end_marker, symbols.end_marker);
                    check_field("last_result", want.last_result, symbols.last_result);
                end
            end
            if (bytes.valid && bytes.ready)
                encode_byte(bytes.data_byte, bytes.last_byte);
        end
        symbols_due = expected_symbols.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import lpse_pkg::*;

    localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;
    localparam int               HOLD_CYCLES = 300;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [REG_W-1:0]  cfg_index = '0;
    logic [TICK_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int symbols_due;
    bit src_idle = 1'b1;
    bit snk_idle = 1'b1;
    bit hold_off = 1'b0;

    lpse_in_if  bytes_if ();
    lpse_out_if symbols_if ();

    led_pulse_symbol_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bytes     (bytes_if),
        .symbols   (symbols_if)
    );

    symbol_stream_check i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .bytes          (bytes_if),
        .symbols        (symbols_if),
        .mismatch_count (mismatch_count),
        .symbols_due    (symbols_due)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic write_reg(input logic [REG_W-1:0] index, input logic [TICK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(input int short_t, input int long_t, input int gap_t);
        write_reg(REG_SHORT_TICKS, TICK_W'(short_t));
        write_reg(REG_LONG_TICKS, TICK_W'(long_t));
        write_reg(REG_RESET_TICKS, TICK_W'(gap_t));
    endtask

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        if (src_idle && bytes_if.valid && $urandom_range(0, 3) == 0)
        begin
            bytes_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        bytes_if.valid     <= 1'b1;
        bytes_if.data_byte <= value;
        bytes_if.last_byte <= is_last;
        do @(posedge clk); while (!bytes_if.ready);
    endtask

    // drop valid and wait until every symbol has come out
    task automatic drain;
        bytes_if.valid <= 1'b0;
        @(posedge clk);
        wait (symbols_due == 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic random_frames(input int count);
        int         sent;
        int         len;
        logic [7:0] value;
        bit         open_end;
        sent = 0;
        while (sent < count)
        begin
            len      = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            open_end = ($urandom_range(0, 5) == 0);
            for (int k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       value = 8'h00;
                    1:       value = 8'hFF;
                    default: value = 8'($urandom);
                endcase
                send_byte(value, !open_end && k == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        symbols_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                symbols_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
                symbols_if.ready <= 1'b1;
            end
            else if (snk_idle && $urandom_range(0, 4) == 0)
            begin
                symbols_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                symbols_if.ready <= 1'b1;
            end
            else
            begin
                symbols_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        bytes_if.valid     = 1'b0;
        bytes_if.data_byte = '0;
        bytes_if.last_byte = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset timing: edge patterns, then a frame ending on the ring's last slot
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        for (int k = 0; k < 8; k++)
            send_byte((k % 2) ? 8'h3C : 8'hA5, k == 7);
        drain();

        // extreme ticks, saturated gap, ignored register slot
        set_timing(1, 32767, 32767);
        write_reg(REG_UNUSED, TICK_W'($urandom));
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h7E, 1'b0);
        send_byte(8'h81, 1'b1);
        drain();

        // zero ticks pass through untouched
        set_timing(0, 0, 0);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: set_timing($urandom_range(1, 60), $urandom_range(1, 120),
                              $urandom_range(0, 3000));
                2: set_timing(32767, 1, 0);
                default: set_timing($urandom_range(1, 32767), $urandom_range(1, 32767),
                                     $urandom_range(0, 32767));
            endcase
            write_reg(REG_UNUSED, TICK_W'($urandom));
            src_idle = (p != 4);
            snk_idle = (p < 3);
            if (p == 1 || p == 2)
                hold_off = 1'b1;
            random_frames(78);
            drain();
        end

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/lpse_pkg.sv
rtl/lpse_if.sv
rtl/lpse_front.sv
rtl/lpse_queue.sv
rtl/lpse_back.sv
rtl/led_pulse_symbol_encoder.sv
tb/sv/symbol_stream_check.sv
tb/sv/testbench.sv
